// File: design/rpy_pkg.sv
// Shared types, widths and constant tables for the roll-pitch-yaw to rotation matrix core.
// Used by the channel interfaces and by every rpy_* module; depends on nothing.
`default_nettype none

package rpy_pkg;

  // CORDIC depth, capped by the arctangent table
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 30;
  localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

  localparam int NLANE  = 3;   // roll, pitch, yaw
  localparam int NENTRY = 9;

  localparam int ANG_W  = 16;
  localparam int OUT_W  = 16;
  localparam int BANG_W = 32;  // binary angle, 2^32 per turn
  localparam int CW     = 34;  // CORDIC datapath
  localparam int TRIG_W = 22;  // Q20 cosine or sine, range +-2^20
  localparam int PROD_W = 2 * TRIG_W;
  localparam int Q60_W  = 64;

  // Angle reduction: 23040 steps per turn = 45 * 512
  localparam int DEG_TURN  = 23040;
  localparam int TURN_OFS  = 2 * DEG_TURN;
  localparam int RED_W     = 17;
  localparam int M_W       = 15;
  localparam int Q1_RECIP  = 46604;  // ceil(2^21 / 45)
  localparam int Q1_SHIFT  = 21;
  localparam int Q1_W      = 9;
  localparam int FRAC_DIV  = 45;
  localparam int FRAC_W    = 23;
  localparam int REM_W     = $clog2(FRAC_DIV);
  localparam int FRAC_WHOLE = (1 << FRAC_W) / FRAC_DIV;
  localparam int FRAC_REM   = (1 << FRAC_W) % FRAC_DIV;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  localparam logic [BANG_W-1:0] ATAN_TBL [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10680862,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41721,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  // floor((r * 2^23 + 22) / 45): low bits of the binary angle for remainder r
  typedef logic [FRAC_W-1:0] rem_tbl_t [FRAC_DIV];

  function automatic rem_tbl_t build_rem_tbl();
    rem_tbl_t tbl;
    for (int i = 0; i < FRAC_DIV; i++) begin
      tbl[i] = FRAC_W'(i * FRAC_WHOLE + (i * FRAC_REM + FRAC_DIV / 2) / FRAC_DIV);
    end
    return tbl;
  endfunction

  localparam rem_tbl_t REM_TBL = build_rem_tbl();

  typedef logic signed [ANG_W-1:0]  angle_t;
  typedef logic signed [BANG_W-1:0] bang_t;
  typedef logic signed [TRIG_W-1:0] trig_val_t;
  typedef logic signed [OUT_W-1:0]  entry_t;
  typedef entry_t mat_t [NENTRY];

  typedef struct packed {
    trig_val_t cos_v;
    trig_val_t sin_v;
  } trig_t;

endpackage

`default_nettype wire

// File: design/rpy_if.sv
// Valid/ready channel interfaces for the rotation matrix core: angle beats in, matrix beats out.
// Depends on rpy_pkg for field widths.
`default_nettype none

interface rpy_in_if;
  import rpy_pkg::*;
  logic   valid;
  logic   ready;
  angle_t roll_deg;
  angle_t pitch_deg;
  angle_t yaw_deg;
  modport source (output valid, output roll_deg, output pitch_deg, output yaw_deg, input ready);
  modport sink   (input valid, input roll_deg, input pitch_deg, input yaw_deg, output ready);
endinterface

interface rpy_out_if;
  import rpy_pkg::*;
  logic   valid;
  logic   ready;
  entry_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  modport source (output valid, output r00, output r01, output r02, output r10, output r11,
                  output r12, output r20, output r21, output r22, input ready);
  modport sink   (input valid, input r00, input r01, input r02, input r10, input r11,
                  input r12, input r20, input r21, input r22, output ready);
endinterface

`default_nettype wire

// File: design/rpy_angle.sv
// Three-stage angle reduction: 1/64 degree to folded 32-bit binary angle, three lanes.
// Depends on rpy_pkg.
`default_nettype none

module rpy_angle (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  rpy_pkg::angle_t    angle_i [rpy_pkg::NLANE],
  output logic               valid_o,
  output rpy_pkg::bang_t     z_o [rpy_pkg::NLANE],
  output logic               neg_o [rpy_pkg::NLANE]
);
  import rpy_pkg::*;

  logic [M_W-1:0]  m_d  [NLANE];
  logic [M_W-1:0]  ma_q [NLANE];
  logic [M_W-1:0]  mb_q [NLANE];
  logic [Q1_W-1:0] q1_d [NLANE];
  logic [Q1_W-1:0] q1_q [NLANE];
  bang_t           z_d  [NLANE];
  logic            neg_d [NLANE];
  bang_t           z_q  [NLANE];
  logic            neg_q [NLANE];
  logic            va_q, vb_q, vc_q;

  // Stage A: modulo one turn by parallel compare and subtract
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      logic signed [RED_W:0] ts;
      logic [RED_W-1:0]      t;
      ts = (RED_W + 1)'(angle_i[l]) + (RED_W + 1)'(TURN_OFS);
      t  = RED_W'(ts);
      priority if (t >= RED_W'(3 * DEG_TURN)) m_d[l] = M_W'(t - RED_W'(3 * DEG_TURN));
      else if (t >= RED_W'(2 * DEG_TURN))     m_d[l] = M_W'(t - RED_W'(2 * DEG_TURN));
      else if (t >= RED_W'(DEG_TURN))         m_d[l] = M_W'(t - RED_W'(DEG_TURN));
      else                                    m_d[l] = M_W'(t);
    end
  end

  // Stage B: quotient by 45 through a reciprocal multiply
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      logic [M_W+RED_W-1:0] p;
      p = (M_W + RED_W)'(ma_q[l]) * (M_W + RED_W)'(Q1_RECIP);
      q1_d[l] = Q1_W'(p >> Q1_SHIFT);
    end
  end

  // Stage C: remainder picks the low bits; fold into +-90 degrees
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      logic [M_W-1:0]   q45;
      logic [REM_W-1:0] r;
      bang_t            b;
      q45 = M_W'(q1_q[l]) * M_W'(FRAC_DIV);
      r   = REM_W'(mb_q[l] - q45);
      b   = bang_t'({q1_q[l], REM_TBL[r]});
      neg_d[l] = (b > bang_t'(32'sh4000_0000)) || (b < -bang_t'(32'sh4000_0000));
      z_d[l]   = neg_d[l] ? {~b[BANG_W-1], b[BANG_W-2:0]} : b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NLANE; l++) begin
        ma_q[l]  <= m_d[l];
        mb_q[l]  <= ma_q[l];
        q1_q[l]  <= q1_d[l];
        z_q[l]   <= z_d[l];
        neg_q[l] <= neg_d[l];
      end
    end
  end

  assign valid_o = vc_q;
  assign z_o     = z_q;
  assign neg_o   = neg_q;

endmodule

`default_nettype wire

// File: design/rpy_cordic.sv
// Pipelined rotation-mode CORDIC, one iteration per stage, plus a round and clamp stage.
// Three lanes share the valid line. Depends on rpy_pkg.
`default_nettype none

module rpy_cordic (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  rpy_pkg::bang_t     z_i [rpy_pkg::NLANE],
  input  wire logic          neg_i [rpy_pkg::NLANE],
  output logic               valid_o,
  output rpy_pkg::trig_t     trig_o [rpy_pkg::NLANE]
);
  import rpy_pkg::*;

  typedef logic signed [CW-1:0] cw_t;

  cw_t   xi  [NSTEP][NLANE];
  cw_t   yi  [NSTEP][NLANE];
  cw_t   zi  [NSTEP][NLANE];
  logic  ni  [NSTEP][NLANE];
  cw_t   x_d [NSTEP][NLANE];
  cw_t   y_d [NSTEP][NLANE];
  cw_t   z_d [NSTEP][NLANE];
  cw_t   x_q [NSTEP][NLANE];
  cw_t   y_q [NSTEP][NLANE];
  cw_t   z_q [NSTEP][NLANE];
  logic  n_q [NSTEP][NLANE];
  logic  v_q [NSTEP];
  trig_t trig_d [NLANE];
  trig_t trig_q [NLANE];
  logic  vo_q;

  function automatic trig_val_t round_q20(cw_t v);
    cw_t r;
    r = (v + cw_t'(512)) >>> 10;
    if (r > cw_t'(1 << 20))       return trig_val_t'(1 << 20);
    else if (r < -cw_t'(1 << 20)) return -trig_val_t'(1 << 20);
    else                          return trig_val_t'(r);
  endfunction

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      if (k == 0) begin : g_first
        assign xi[k][l] = CORDIC_GAIN;
        assign yi[k][l] = '0;
        assign zi[k][l] = cw_t'(z_i[l]);
        assign ni[k][l] = neg_i[l];
      end else begin : g_next
        assign xi[k][l] = x_q[k-1][l];
        assign yi[k][l] = y_q[k-1][l];
        assign zi[k][l] = z_q[k-1][l];
        assign ni[k][l] = n_q[k-1][l];
      end
      // rotate toward zero residual angle
      assign x_d[k][l] = (zi[k][l] >= 0) ? xi[k][l] - (yi[k][l] >>> k)
                                         : xi[k][l] + (yi[k][l] >>> k);
      assign y_d[k][l] = (zi[k][l] >= 0) ? yi[k][l] + (xi[k][l] >>> k)
                                         : yi[k][l] - (xi[k][l] >>> k);
      assign z_d[k][l] = (zi[k][l] >= 0) ? zi[k][l] - cw_t'(ATAN_TBL[k])
                                         : zi[k][l] + cw_t'(ATAN_TBL[k]);
    end
  end

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      cw_t xf, yf;
      xf = n_q[NSTEP-1][l] ? -x_q[NSTEP-1][l] : x_q[NSTEP-1][l];
      yf = n_q[NSTEP-1][l] ? -y_q[NSTEP-1][l] : y_q[NSTEP-1][l];
      trig_d[l].cos_v = round_q20(xf);
      trig_d[l].sin_v = round_q20(yf);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTEP; k++) v_q[k] <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < NSTEP; k++) v_q[k] <= v_q[k-1];
      vo_q <= v_q[NSTEP-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NSTEP; k++) begin
        for (int l = 0; l < NLANE; l++) begin
          x_q[k][l] <= x_d[k][l];
          y_q[k][l] <= y_d[k][l];
          z_q[k][l] <= z_d[k][l];
          n_q[k][l] <= ni[k][l];
        end
      end
      for (int l = 0; l < NLANE; l++) trig_q[l] <= trig_d[l];
    end
  end

  assign valid_o = vo_q;
  assign trig_o  = trig_q;

endmodule

`default_nettype wire

// File: design/rpy_matrix.sv
// Four-stage matrix former: pair products, split triple products, recombine, sum/round/clamp.
// Depends on rpy_pkg.
`default_nettype none

module rpy_matrix (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  rpy_pkg::trig_t     trig_i [rpy_pkg::NLANE],
  output logic               valid_o,
  output rpy_pkg::mat_t      mat_o
);
  import rpy_pkg::*;

  localparam int NTRI = 4;
  localparam int HALF = TRIG_W;

  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [PROD_W:0]    lprod_t;
  typedef logic signed [Q60_W-1:0]   q60_t;

  trig_val_t cr, sr, cp, sp, cy, sy;
  prod_t     a_q, b_q;
  prod_t     d1_q [NENTRY];
  prod_t     d2_q [NENTRY];
  prod_t     d3_q [NENTRY];
  trig_val_t sr_q, cr_q;
  prod_t     th_q [NTRI];
  lprod_t    tl_q [NTRI];
  q60_t      t_q  [NTRI];
  mat_t      mat_d, mat_q;
  logic      v1_q, v2_q, v3_q, v4_q;

  assign cr = trig_i[0].cos_v;
  assign sr = trig_i[0].sin_v;
  assign cp = trig_i[1].cos_v;
  assign sp = trig_i[1].sin_v;
  assign cy = trig_i[2].cos_v;
  assign sy = trig_i[2].sin_v;

  function automatic entry_t to_q14(q60_t v);
    q60_t r;
    r = (v + (q60_t'(1) <<< 45)) >>> 46;
    if (r > q60_t'(16384))       return entry_t'(16384);
    else if (r < -q60_t'(16384)) return entry_t'(-16384);
    else                         return entry_t'(r);
  endfunction

  function automatic q60_t up20(prod_t v);
    return q60_t'(v) <<< 20;
  endfunction

  always_comb begin
    for (int e = 0; e < NENTRY; e++) mat_d[e] = '0;
    mat_d[0] = to_q14(up20(d3_q[0]));
    mat_d[1] = to_q14(t_q[0] - up20(d3_q[1]));
    mat_d[2] = to_q14(t_q[1] + up20(d3_q[2]));
    mat_d[3] = to_q14(up20(d3_q[3]));
    mat_d[4] = to_q14(t_q[2] + up20(d3_q[4]));
    mat_d[5] = to_q14(t_q[3] - up20(d3_q[5]));
    mat_d[6] = to_q14(-up20(d3_q[6]));
    mat_d[7] = to_q14(up20(d3_q[7]));
    mat_d[8] = to_q14(up20(d3_q[8]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // pair products in Q40
      a_q     <= cy * sp;
      b_q     <= sy * sp;
      d1_q[0] <= cp * cy;
      d1_q[1] <= sy * cr;
      d1_q[2] <= sy * sr;
      d1_q[3] <= sy * cp;
      d1_q[4] <= cy * cr;
      d1_q[5] <= cy * sr;
      d1_q[6] <= prod_t'(sp) <<< 20;
      d1_q[7] <= cp * sr;
      d1_q[8] <= cp * cr;
      sr_q    <= sr;
      cr_q    <= cr;
      // triple products split into high and low halves of the pair product
      th_q[0] <= trig_val_t'(a_q >>> HALF) * sr_q;
      tl_q[0] <= $signed({1'b0, a_q[HALF-1:0]}) * sr_q;
      th_q[1] <= trig_val_t'(a_q >>> HALF) * cr_q;
      tl_q[1] <= $signed({1'b0, a_q[HALF-1:0]}) * cr_q;
      th_q[2] <= trig_val_t'(b_q >>> HALF) * sr_q;
      tl_q[2] <= $signed({1'b0, b_q[HALF-1:0]}) * sr_q;
      th_q[3] <= trig_val_t'(b_q >>> HALF) * cr_q;
      tl_q[3] <= $signed({1'b0, b_q[HALF-1:0]}) * cr_q;
      for (int i = 0; i < NTRI; i++) begin
        t_q[i] <= (q60_t'(th_q[i]) <<< HALF) + q60_t'(tl_q[i]);
      end
      for (int e = 0; e < NENTRY; e++) begin
        d2_q[e] <= d1_q[e];
        d3_q[e] <= d2_q[e];
      end
      mat_q <= mat_d;
    end
  end

  assign valid_o = v4_q;
  assign mat_o   = mat_q;

endmodule

`default_nettype wire

// File: design/rpy_to_rotation_matrix_core.sv
// Registered stages from input beat to output valid:
//   3 angle reduction, one per CORDIC iteration, 1 round, 4 matrix, 1 output register.
// Throughput: one beat per cycle while the skid register is empty; the CORDIC and matrix stages all advance together.
// Reset: asynchronous, active low; clears all valid bits, output and skid valids included.
// Depends on rpy_pkg, rpy_if, rpy_angle, rpy_cordic, rpy_matrix.
`default_nettype none

module rpy_to_rotation_matrix_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rpy_in_if.sink    in_i,
  rpy_out_if.source out_o
);
  import rpy_pkg::*;

  logic   en;
  angle_t ang [NLANE];
  logic   av;
  bang_t  az [NLANE];
  logic   an [NLANE];
  logic   cv;
  trig_t  ct [NLANE];
  logic   mv;
  mat_t   mat;
  logic   out_free;
  logic   out_valid_q, skid_valid_q;
  mat_t   out_data_q, skid_data_q;

  // the whole pipeline holds only while the skid register is full
  assign en         = !skid_valid_q;
  assign in_i.ready = en;

  assign ang[0] = in_i.roll_deg;
  assign ang[1] = in_i.pitch_deg;
  assign ang[2] = in_i.yaw_deg;

  rpy_angle u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .angle_i (ang),
    .valid_o (av),
    .z_o     (az),
    .neg_o   (an)
  );

  rpy_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (av),
    .z_i     (az),
    .neg_i   (an),
    .valid_o (cv),
    .trig_o  (ct)
  );

  rpy_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cv),
    .trig_i  (ct),
    .valid_o (mv),
    .mat_o   (mat)
  );

  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= mv;
      end
    end else if (mv && en) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : mat;
    end else if (mv && en) begin
      skid_data_q <= mat;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.r00   = out_data_q[0];
  assign out_o.r01   = out_data_q[1];
  assign out_o.r02   = out_data_q[2];
  assign out_o.r10   = out_data_q[3];
  assign out_o.r11   = out_data_q[4];
  assign out_o.r12   = out_data_q[5];
  assign out_o.r20   = out_data_q[6];
  assign out_o.r21   = out_data_q[7];
  assign out_o.r22   = out_data_q[8];

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_o.valid && !out_o.ready))
    else $error("skid register filled without an output stall");

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_o.valid)
    else $error("skid register holds a beat while output is empty");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_o.ready |=> out_o.valid && !skid_valid_q)
    else $error("skid beat not moved to output after a taken beat");

endmodule

`default_nettype wire
